@@ rtl/srctl_pkg.sv @@
// shared types and constants for the stepper ramp controller
// no dependencies; used by the front end, the back end and the top level

package srctl_pkg;

    // input word kinds
    localparam logic [2:0] KIND_MOTOR = 3'd0;
    localparam logic [2:0] KIND_RAMP  = 3'd1;
    localparam logic [2:0] KIND_SET   = 3'd2;
    localparam logic [2:0] KIND_STOP  = 3'd3;
    localparam logic [2:0] KIND_START = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RAMP_DIVIDER     = 2'd0;
    localparam logic [1:0] CFG_PERIOD_NUMERATOR = 2'd1;
    localparam logic [1:0] CFG_SPEED_LIMIT      = 2'd2;

    // configuration reset values
    localparam logic [7:0]  RAMP_DIVIDER_RST     = 8'd6;
    localparam logic [15:0] PERIOD_NUMERATOR_RST = 16'd1500;
    localparam logic [7:0]  SPEED_LIMIT_RST      = 8'd240;

    // drive state reset values
    localparam logic [3:0] COILS_IDLE = 4'hF;
    localparam logic [2:0] PHASE_RST  = 3'd3;

    // divider length: one quotient bit per cycle
    localparam int DIV_STEPS = 16;

    // classified command codes
    typedef enum logic [2:0] {
        OP_MOTOR   = 3'd0,
        OP_RAMP    = 3'd1,
        OP_SET_OK  = 3'd2,
        OP_SET_BAD = 3'd3,
        OP_STOP    = 3'd4,
        OP_START   = 3'd5,
        OP_NONE    = 3'd6
    } t_op;

    // command word passed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] speed;
        logic       dir;
    } t_cmd;

    // configuration register set
    typedef struct packed {
        logic [7:0]  ramp_divider;
        logic [15:0] period_numerator;
        logic [7:0]  speed_limit;
    } t_cfg;

endpackage

@@ rtl/srctl_front.sv @@
// front end: accepts input words, classifies them into commands, queues them
// depends on srctl_pkg

module srctl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_in_kind,
    input  logic [9:0]          i_in_target_speed,
    input  logic                i_in_target_dir,
    input  logic [7:0]          i_speed_limit,
    input  logic                i_pop,
    output logic                o_head_valid,
    output srctl_pkg::t_cmd     o_head
);

    srctl_pkg::t_cmd r_q [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    srctl_pkg::t_cmd w_cmd;
    logic            w_push;
    logic            w_pop;

    // classify the incoming word
    always_comb begin
        w_cmd.speed = i_in_target_speed[7:0];
        w_cmd.dir   = i_in_target_dir;
        unique case (i_in_kind)
            srctl_pkg::KIND_MOTOR: w_cmd.op = srctl_pkg::OP_MOTOR;
            srctl_pkg::KIND_RAMP:  w_cmd.op = srctl_pkg::OP_RAMP;
            srctl_pkg::KIND_SET: begin
                if (i_in_target_speed <= {2'b00, i_speed_limit}) begin
                    w_cmd.op = srctl_pkg::OP_SET_OK;
                end else begin
                    w_cmd.op = srctl_pkg::OP_SET_BAD;
                end
            end
            srctl_pkg::KIND_STOP:  w_cmd.op = srctl_pkg::OP_STOP;
            srctl_pkg::KIND_START: w_cmd.op = srctl_pkg::OP_START;
            default:               w_cmd.op = srctl_pkg::OP_NONE;
        endcase
    end

    // two-entry queue
    assign o_in_stall   = (r_count == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_q[r_rptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

endmodule

@@ rtl/srctl_back.sv @@
// back end: executes commands, holds drive state, divides out the step period
// depends on srctl_pkg

module srctl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srctl_pkg::t_cfg     i_cfg,
    input  logic                i_head_valid,
    input  srctl_pkg::t_cmd     i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [3:0]          o_out_coil_pattern,
    output logic [7:0]          o_out_speed_now,
    output logic                o_out_dir_now,
    output logic                o_out_stepped,
    output logic                o_out_rejected,
    output logic                o_out_halted
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_cur_speed, n_cur_speed;
    logic        r_cur_dir, n_cur_dir;
    logic [7:0]  r_goal_speed, n_goal_speed;
    logic        r_goal_dir, n_goal_dir;
    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_coils, n_coils;
    logic [15:0] r_step_count, n_step_count;
    logic [7:0]  r_ramp_count, n_ramp_count;
    logic        r_stop, n_stop;
    logic [15:0] r_quo, n_quo;
    logic [7:0]  r_rem, n_rem;
    logic [3:0]  r_div_cnt, n_div_cnt;

    logic        r_out_valid;
    logic [3:0]  r_out_coils;
    logic [7:0]  r_out_speed;
    logic        r_out_dir;
    logic        r_out_stepped;
    logic        r_out_rejected;
    logic        r_out_halted;

    logic        w_out_free;
    logic        w_load;
    logic        w_stepped;
    logic        w_rejected;
    logic [8:0]  w_rem_sh;
    logic [8:0]  w_rem_sub;
    logic        w_ge;
    logic [15:0] w_period;
    logic [15:0] w_step_inc;
    logic [7:0]  w_ramp_inc;
    logic [7:0]  w_ramp_div;
    logic [2:0]  w_phase_nx;

    // next phase position, forward 1..4 or reverse 4..1
    function automatic logic [2:0] phase_next(input logic [2:0] ph, input logic dir);
        logic [2:0] res;
        if (!dir) begin
            res = (ph >= 3'd1 && ph <= 3'd3) ? ph + 3'd1 : 3'd1;
        end else begin
            res = (ph >= 3'd2 && ph <= 3'd4) ? ph - 3'd1 : 3'd4;
        end
        return res;
    endfunction

    // coil bits after entering a phase position
    function automatic logic [3:0] coil_next(input logic [2:0] ph, input logic [3:0] c);
        logic [3:0] res;
        res = c;
        case (ph)
            3'd1: begin res[3] = 1'b0; res[1] = 1'b1; end
            3'd2: begin res[2] = 1'b0; res[0] = 1'b1; end
            3'd3: begin res[1] = 1'b0; res[3] = 1'b1; end
            default: begin res[0] = 1'b0; res[2] = 1'b1; end
        endcase
        return res;
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;

    // restoring divide step: period_numerator / cur_speed
    assign w_rem_sh  = {r_rem, r_quo[15]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_cur_speed});
    assign w_rem_sub = w_rem_sh - {1'b0, r_cur_speed};

    assign w_period   = (r_quo == 16'd0) ? 16'd1 : r_quo;
    assign w_step_inc = r_step_count + 16'd1;
    assign w_ramp_inc = r_ramp_count + 8'd1;
    assign w_ramp_div = (i_cfg.ramp_divider == 8'd0) ? 8'd1 : i_cfg.ramp_divider;
    assign w_phase_nx = phase_next(r_phase, r_cur_dir);

    // command execution
    always_comb begin
        n_state      = r_state;
        n_cur_speed  = r_cur_speed;
        n_cur_dir    = r_cur_dir;
        n_goal_speed = r_goal_speed;
        n_goal_dir   = r_goal_dir;
        n_phase      = r_phase;
        n_coils      = r_coils;
        n_step_count = r_step_count;
        n_ramp_count = r_ramp_count;
        n_stop       = r_stop;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div_cnt    = r_div_cnt;
        o_pop        = 1'b0;
        w_load       = 1'b0;
        w_stepped    = 1'b0;
        w_rejected   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid && w_out_free) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        srctl_pkg::OP_MOTOR: begin
                            if (!r_stop && r_cur_speed != 8'd0) begin
                                n_quo     = i_cfg.period_numerator;
                                n_rem     = 8'd0;
                                n_div_cnt = 4'd0;
                                n_state   = S_DIV;
                            end else begin
                                w_load = 1'b1;
                            end
                        end
                        srctl_pkg::OP_RAMP: begin
                            w_load = 1'b1;
                            if (w_ramp_inc >= w_ramp_div) begin
                                n_ramp_count = 8'd0;
                                if (r_cur_speed != r_goal_speed || r_cur_dir != r_goal_dir) begin
                                    if (r_goal_speed == 8'd0) begin
                                        if (r_cur_speed == 8'd0) begin
                                            n_cur_dir = r_goal_dir;
                                        end
                                        n_cur_speed = 8'd0;
                                        n_coils     = srctl_pkg::COILS_IDLE;
                                    end else if (r_cur_dir == r_goal_dir) begin
                                        if (r_cur_speed < r_goal_speed) begin
                                            n_cur_speed = r_cur_speed + 8'd1;
                                        end else begin
                                            n_cur_speed = r_cur_speed - 8'd1;
                                        end
                                    end else if (r_cur_speed == 8'd0) begin
                                        n_cur_dir = r_goal_dir;
                                    end else begin
                                        // slowing for a reversal, switch at zero
                                        n_cur_speed = r_cur_speed - 8'd1;
                                        if (r_cur_speed == 8'd1) begin
                                            n_cur_dir = r_goal_dir;
                                        end
                                    end
                                end
                            end else begin
                                n_ramp_count = w_ramp_inc;
                            end
                        end
                        srctl_pkg::OP_SET_OK: begin
                            w_load       = 1'b1;
                            n_goal_speed = i_head.speed;
                            n_goal_dir   = i_head.dir;
                        end
                        srctl_pkg::OP_SET_BAD: begin
                            w_load     = 1'b1;
                            w_rejected = 1'b1;
                        end
                        srctl_pkg::OP_STOP: begin
                            w_load      = 1'b1;
                            n_stop      = 1'b1;
                            n_coils     = srctl_pkg::COILS_IDLE;
                            n_cur_speed = 8'd0;
                        end
                        srctl_pkg::OP_START: begin
                            w_load       = 1'b1;
                            n_cur_speed  = 8'd0;
                            n_cur_dir    = 1'b0;
                            n_goal_speed = 8'd0;
                            n_goal_dir   = 1'b0;
                            n_phase      = srctl_pkg::PHASE_RST;
                            n_coils      = srctl_pkg::COILS_IDLE;
                            n_step_count = 16'd0;
                            n_ramp_count = 8'd0;
                            n_stop       = 1'b0;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_quo = {r_quo[14:0], w_ge};
                n_rem = w_ge ? w_rem_sub[7:0] : w_rem_sh[7:0];
                n_div_cnt = r_div_cnt + 4'd1;
                if (r_div_cnt == 4'(srctl_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (w_step_inc >= w_period) begin
                        n_step_count = 16'd0;
                        n_phase      = w_phase_nx;
                        n_coils      = coil_next(w_phase_nx, r_coils);
                        w_stepped    = 1'b1;
                    end else begin
                        n_step_count = w_step_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // drive state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur_speed  <= 8'd0;
            r_cur_dir    <= 1'b0;
            r_goal_speed <= 8'd0;
            r_goal_dir   <= 1'b0;
            r_phase      <= srctl_pkg::PHASE_RST;
            r_coils      <= srctl_pkg::COILS_IDLE;
            r_step_count <= 16'd0;
            r_ramp_count <= 8'd0;
            r_stop       <= 1'b0;
            r_div_cnt    <= 4'd0;
        end else begin
            r_state      <= n_state;
            r_cur_speed  <= n_cur_speed;
            r_cur_dir    <= n_cur_dir;
            r_goal_speed <= n_goal_speed;
            r_goal_dir   <= n_goal_dir;
            r_phase      <= n_phase;
            r_coils      <= n_coils;
            r_step_count <= n_step_count;
            r_ramp_count <= n_ramp_count;
            r_stop       <= n_stop;
            r_div_cnt    <= n_div_cnt;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_coils    <= n_coils;
            r_out_speed    <= n_cur_speed;
            r_out_dir      <= n_cur_dir;
            r_out_stepped  <= w_stepped;
            r_out_rejected <= w_rejected;
            r_out_halted   <= n_stop;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_coil_pattern = r_out_coils;
    assign o_out_speed_now    = r_out_speed;
    assign o_out_dir_now      = r_out_dir;
    assign o_out_stepped      = r_out_stepped;
    assign o_out_rejected     = r_out_rejected;
    assign o_out_halted       = r_out_halted;

endmodule

@@ rtl/stepper_ramp_controller.sv @@
// Stepper ramp controller top level: configuration registers, front end, back end.
// Flow: an accepted input word is queued; the back end pops it and registers its result
// word, after a bit-serial period divide for a motor tick at nonzero speed while running.
// Throughput: one word per cycle while the output is not stalled; none while dividing.
// A two-word queue lets the input side keep accepting while the back end divides.
// Reset: synchronous active-low; drive state, queue and configuration return to defaults.

module stepper_ramp_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_in_kind,
    input  logic [9:0]  i_in_target_speed,
    input  logic        i_in_target_dir,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_out_coil_pattern,
    output logic [7:0]  o_out_speed_now,
    output logic        o_out_dir_now,
    output logic        o_out_stepped,
    output logic        o_out_rejected,
    output logic        o_out_halted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    srctl_pkg::t_cfg r_cfg;
    srctl_pkg::t_cmd w_head;
    logic            w_head_valid;
    logic            w_pop;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_divider     <= srctl_pkg::RAMP_DIVIDER_RST;
            r_cfg.period_numerator <= srctl_pkg::PERIOD_NUMERATOR_RST;
            r_cfg.speed_limit      <= srctl_pkg::SPEED_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                srctl_pkg::CFG_RAMP_DIVIDER:     r_cfg.ramp_divider     <= i_cfg_data[7:0];
                srctl_pkg::CFG_PERIOD_NUMERATOR: r_cfg.period_numerator <= i_cfg_data;
                srctl_pkg::CFG_SPEED_LIMIT:      r_cfg.speed_limit      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front end: accept, classify, queue
    srctl_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_kind         (i_in_kind),
        .i_in_target_speed (i_in_target_speed),
        .i_in_target_dir   (i_in_target_dir),
        .i_speed_limit     (r_cfg.speed_limit),
        .i_pop             (w_pop),
        .o_head_valid      (w_head_valid),
        .o_head            (w_head)
    );

    // back end: execute and report
    srctl_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_head_valid       (w_head_valid),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_coil_pattern (o_out_coil_pattern),
        .o_out_speed_now    (o_out_speed_now),
        .o_out_dir_now      (o_out_dir_now),
        .o_out_stepped      (o_out_stepped),
        .o_out_rejected     (o_out_rejected),
        .o_out_halted       (o_out_halted)
    );

endmodule

@@ rtl/srctl_checker.sv @@
// port-level checks for the stepper ramp controller
// depends on stepper_ramp_controller ports; attached with bind

module srctl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_out_coil_pattern,
    input logic [7:0]  o_out_speed_now,
    input logic        o_out_stepped,
    input logic        o_out_rejected,
    input logic        o_out_halted
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_coil_pattern)
            && $stable(o_out_speed_now) && $stable(o_out_stepped))
        else $error("result word changed while stalled");

    // a step only happens while running at nonzero speed
    a_step_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_stepped |-> o_out_speed_now != 8'd0 && !o_out_halted)
        else $error("step reported while stopped or at zero speed");

    // a rejected setpoint never steps
    a_reject_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rejected |-> !o_out_stepped)
        else $error("rejected setpoint reported a step");

    // nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

endmodule

bind stepper_ramp_controller srctl_checker u_srctl_checker (.*);
